>>> hdl/bdj3_pkg.sv
// Package for the band depth block: widths, constants, word types, state type.
// No dependencies.
package bdj3_pkg;

  localparam int MAX_CURVES_DEF = 64;
  localparam int MAX_POINTS_DEF = 256;
  localparam int SAMPLE_W = 32;
  localparam int FRAC_BITS = 24;
  localparam int NCFG_W = 7;
  localparam int PCFG_W = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam int CURVE_NUM_W = 6;
  localparam int PAIR_CNT_W = 11;
  localparam int TRIPLE_CNT_W = 16;
  localparam int DEPTH_W = 26;
  localparam int DIV_DEN_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CURVES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [CURVE_NUM_W-1:0]  curve_number;
    logic [PAIR_CNT_W-1:0]   pair_count;
    logic [TRIPLE_CNT_W-1:0] triple_count;
    logic [DEPTH_W-1:0]      depth_value;
    logic                    last_result;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_WAIT,
    ST_COMMIT,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Control handed from the sequencer to the cell row.
  typedef struct packed {
    logic clear;     // zero all tallies
    logic start;     // begin a band test, each active cell marked inside
    logic test;      // compare broadcast sample/bounds this cycle
    logic commit;    // add results of finished band to tallies
    logic triple;    // band under test is a triple
    logic shift;     // move tallies one cell toward the output end
  } cell_ctl_t;

endpackage

>>> hdl/bdj3_if.sv
// Valid/ready channel interface carrying a payload of a given type.
// Depends on nothing.
interface bdj3_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/bdj3_cell.sv
// One cell of the curve row: inside flag and band tallies for one curve.
// Depends on bdj3_pkg.
module bdj3_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bdj3_pkg::cell_ctl_t                  ctl,
  input  logic                                 sel,
  input  logic                                 active,
  input  logic [bdj3_pkg::SAMPLE_W-1:0]        samp,
  input  logic [bdj3_pkg::SAMPLE_W-1:0]        lo,
  input  logic [bdj3_pkg::SAMPLE_W-1:0]        hi,
  input  logic [bdj3_pkg::PAIR_CNT_W-1:0]      pair_in,
  input  logic [bdj3_pkg::TRIPLE_CNT_W-1:0]    trip_in,
  output logic [bdj3_pkg::PAIR_CNT_W-1:0]      pair_out,
  output logic [bdj3_pkg::TRIPLE_CNT_W-1:0]    trip_out
);
  logic                              in_r;
  logic [bdj3_pkg::PAIR_CNT_W-1:0]   pair_r;
  logic [bdj3_pkg::TRIPLE_CNT_W-1:0] trip_r;
  logic                              ok;

  assign ok = (samp >= lo) && (samp <= hi);
  assign pair_out = pair_r;
  assign trip_out = trip_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      in_r   <= 1'b0;
      pair_r <= '0;
      trip_r <= '0;
    end else if (ctl.shift) begin
      pair_r <= pair_in;
      trip_r <= trip_in;
    end else begin
      if (ctl.start) in_r <= active;
      else if (ctl.test && sel && !ok) in_r <= 1'b0;
      if (ctl.commit && in_r) begin
        if (ctl.triple) trip_r <= trip_r + 1'b1;
        else pair_r <= pair_r + 1'b1;
      end
    end
  end
endmodule

>>> hdl/bdj3_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module bdj3_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial;

  assign trial = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
  assign quo = q_r;
  assign done = busy_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
      q_r    <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else begin
        cnt_r <= cnt_r - 1'b1;
        if (trial >= {1'b0, den_r}) begin
          rem_r <= trial - {1'b0, den_r};
          q_r   <= {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[NUM_W-2:0], 1'b0};
        end
      end
    end
  end
endmodule

>>> hdl/band_depth_j3.sv
// Top level of the band depth block: sample memory, sequencer, cell row, divider.
// Depends on bdj3_pkg, bdj3_if, bdj3_cell, bdj3_div.
//
//  channel | dir | payload
//  in_     | in  | sample_value
//  out_    | out | curve_number, pair_count, triple_count, depth_value, last_result
//  cfg_    | in  | cfg_index, cfg_data
//
// Loading takes one word per cycle; the input stalls while a configuration word is offered.
// After the last word each band reads, at every point, its k = 2 or 3 bound samples and
// then the samples of all n curves. Each result then needs two serial divides and waits for
// out_ready. Input and configuration are refused until the last result is taken.
// Reset is synchronous; the sample memory needs no clearing since a frame reads only its own.
module band_depth_j3 #(
  parameter int MAX_CURVES = bdj3_pkg::MAX_CURVES_DEF,
  parameter int MAX_POINTS = bdj3_pkg::MAX_POINTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bdj3_if.sink   in_ch,
  bdj3_if.source out_ch,
  bdj3_if.sink   cfg_ch
);
  localparam int CW = $clog2(MAX_CURVES);
  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int AW = $clog2(MAX_CURVES * MAX_POINTS);
  localparam int NUMW = bdj3_pkg::TRIPLE_CNT_W + bdj3_pkg::FRAC_BITS;
  localparam int DW = bdj3_pkg::DIV_DEN_W;
  localparam int SW = bdj3_pkg::SAMPLE_W;
  localparam longint RECIP3 = 87382;
  localparam int RECIP_SH = 18;

  localparam logic [1:0] SP_A = 2'd0;
  localparam logic [1:0] SP_B = 2'd1;
  localparam logic [1:0] SP_C = 2'd2;
  localparam logic [1:0] SP_CURVE = 2'd3;

  localparam logic [1:0] DP_PAIR_GO = 2'd0;
  localparam logic [1:0] DP_PAIR_WAIT = 2'd1;
  localparam logic [1:0] DP_TRIP_GO = 2'd2;
  localparam logic [1:0] DP_TRIP_WAIT = 2'd3;

  logic [bdj3_pkg::NCFG_W-1:0] ncfg_r;
  logic [bdj3_pkg::PCFG_W-1:0] pcfg_r;
  logic [CW:0] n_eff;
  logic [PW:0] p_eff;

  always_comb begin
    n_eff = (ncfg_r < bdj3_pkg::NCFG_W'(3)) ? (CW+1)'(3)
          : (32'(ncfg_r) > MAX_CURVES) ? (CW+1)'(MAX_CURVES) : (CW+1)'(ncfg_r);
    p_eff = (pcfg_r == '0) ? (PW+1)'(1)
          : (32'(pcfg_r) > MAX_POINTS) ? (PW+1)'(MAX_POINTS) : (PW+1)'(pcfg_r);
  end

  logic [SW-1:0] mem [MAX_CURVES*MAX_POINTS];
  logic [SW-1:0] rd_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] base_r;
  logic [AW:0]   load_r;
  logic [AW:0]   total;
  logic          load_last;
  assign total = (AW+1)'(n_eff) * (AW+1)'(p_eff);
  assign load_last = (load_r + 1'b1) == total;

  bdj3_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] a_r, b_r, c_r, i_r, k_r;
  logic [PW-1:0] j_r;
  logic [1:0]    sp_r;
  logic          trip_r;
  logic [SW-1:0] lo_r, hi_r;
  logic          rd_first_r, rd_ext_r, rd_test_r;
  logic [CW-1:0] rd_cur_r;
  logic          last_r;
  logic [1:0]    dph_r;
  logic [bdj3_pkg::DEPTH_W-1:0] dsum_r;
  logic          ovalid_r;

  bdj3_pkg::cell_ctl_t ctl;
  logic [bdj3_pkg::PAIR_CNT_W-1:0]   pc [MAX_CURVES+1];
  logic [bdj3_pkg::TRIPLE_CNT_W-1:0] tc [MAX_CURVES+1];
  assign pc[MAX_CURVES] = '0;
  assign tc[MAX_CURVES] = '0;

  logic in_fire, cfg_fire, out_fire;
  assign in_ch.ready = (st_r == bdj3_pkg::ST_LOAD) && !cfg_ch.valid;
  assign cfg_ch.ready = (st_r == bdj3_pkg::ST_LOAD);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign out_ch.valid = ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncfg_r <= 7'd64;
      pcfg_r <= 9'd256;
    end else if (cfg_fire) begin
      if (cfg_ch.data.idx == bdj3_pkg::REG_NUM_CURVES) begin
        ncfg_r <= cfg_ch.data.value[bdj3_pkg::NCFG_W-1:0];
      end else if (cfg_ch.data.idx == bdj3_pkg::REG_NUM_POINTS) begin
        pcfg_r <= cfg_ch.data.value;
      end
    end
  end

  logic [CW:0] a1, a2, b1, c1;
  logic a_more, b_more, c_more, band_done;
  logic jlast, ilast;
  assign a1 = {1'b0, a_r} + 1'b1;
  assign a2 = {1'b0, a_r} + (CW+1)'(2);
  assign b1 = {1'b0, b_r} + 1'b1;
  assign c1 = {1'b0, c_r} + 1'b1;
  assign a_more = a2 < n_eff;
  assign b_more = b1 < n_eff;
  assign c_more = c1 < n_eff;
  assign band_done = !b_more && !a_more;
  assign jlast = ({1'b0, j_r} + 1'b1) == p_eff;
  assign ilast = ({1'b0, i_r} + 1'b1) == n_eff;

  logic ddone;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      bdj3_pkg::ST_LOAD:   if (in_fire && load_last) st_nxt = bdj3_pkg::ST_START;
      bdj3_pkg::ST_START:  st_nxt = bdj3_pkg::ST_SCAN;
      bdj3_pkg::ST_SCAN:   if (sp_r == SP_CURVE && ilast && jlast) st_nxt = bdj3_pkg::ST_WAIT;
      bdj3_pkg::ST_WAIT:   st_nxt = bdj3_pkg::ST_COMMIT;
      bdj3_pkg::ST_COMMIT: st_nxt = band_done ? bdj3_pkg::ST_DIV : bdj3_pkg::ST_START;
      bdj3_pkg::ST_DIV:    if (dph_r == DP_TRIP_WAIT && ddone) st_nxt = bdj3_pkg::ST_EMIT;
      bdj3_pkg::ST_EMIT:
        if (out_fire) st_nxt = last_r ? bdj3_pkg::ST_LOAD : bdj3_pkg::ST_DIV;
      default: st_nxt = bdj3_pkg::ST_LOAD;
    endcase
  end

  // Each point first reads the band members for its bounds, then every curve in turn.
  always_comb begin
    case (sp_r)
      SP_A:    rd_addr = base_r + AW'(a_r);
      SP_B:    rd_addr = base_r + AW'(b_r);
      SP_C:    rd_addr = base_r + AW'(c_r);
      default: rd_addr = base_r + AW'(i_r);
    endcase
  end

  logic dstart;
  always_comb begin
    ctl = '0;
    ctl.triple = trip_r;
    ctl.clear = (st_r == bdj3_pkg::ST_LOAD) && in_fire && load_last;
    ctl.start = (st_r == bdj3_pkg::ST_START);
    ctl.test = rd_test_r;
    ctl.commit = (st_r == bdj3_pkg::ST_COMMIT);
    ctl.shift = (st_r == bdj3_pkg::ST_EMIT) && out_fire;
    dstart = (st_r == bdj3_pkg::ST_DIV) && (dph_r == DP_PAIR_GO || dph_r == DP_TRIP_GO);
  end

  // Divider inputs use the head cell of the row.
  logic [NUMW-1:0] dnum, dq;
  logic [DW-1:0] c2_r, c3x_r, c3_r;
  // C(n,2)*(n-2) is a multiple of three, so the reciprocal product is exact
  // while C(n,3) stays below 2^17.
  always_ff @(posedge clk) begin
    c2_r <= DW'((32'(n_eff) * (32'(n_eff) - 32'd1)) >> 1);
    c3x_r <= DW'(32'(c2_r) * (32'(n_eff) - 32'd2));
    c3_r <= DW'((64'(c3x_r) * 64'(RECIP3)) >> RECIP_SH);
  end
  assign dnum = (dph_r == DP_PAIR_GO) ? NUMW'({pc[0], {bdj3_pkg::FRAC_BITS{1'b0}}})
                                      : NUMW'({tc[0], {bdj3_pkg::FRAC_BITS{1'b0}}});

  bdj3_div #(.NUM_W(NUMW), .DEN_W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum),
    .den(dph_r == DP_PAIR_GO ? c2_r : c3_r), .done(ddone), .quo(dq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bdj3_pkg::ST_LOAD;
      load_r <= '0;
      sp_r <= SP_A; j_r <= '0; i_r <= '0; base_r <= '0;
      a_r <= '0; b_r <= '0; c_r <= '0; trip_r <= 1'b0;
      dph_r <= DP_PAIR_GO; ovalid_r <= 1'b0; k_r <= '0;
      dsum_r <= '0; last_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        bdj3_pkg::ST_LOAD:
          if (cfg_fire) load_r <= '0;
          else if (in_fire) begin
            if (load_last) begin
              load_r <= '0;
              a_r <= '0; b_r <= CW'(1); c_r <= CW'(2); trip_r <= 1'b0;
            end else load_r <= load_r + 1'b1;
          end
        bdj3_pkg::ST_START: begin
          sp_r <= SP_A; j_r <= '0; i_r <= '0; base_r <= '0;
        end
        bdj3_pkg::ST_SCAN:
          case (sp_r)
            SP_A: sp_r <= SP_B;
            SP_B: sp_r <= trip_r ? SP_C : SP_CURVE;
            SP_C: sp_r <= SP_CURVE;
            default: begin
              if (ilast) begin
                i_r <= '0;
                if (!jlast) begin
                  j_r <= j_r + 1'b1;
                  base_r <= base_r + AW'(n_eff);
                  sp_r <= SP_A;
                end
              end else i_r <= i_r + 1'b1;
            end
          endcase
        bdj3_pkg::ST_COMMIT:
          if (!trip_r && b_more) begin
            trip_r <= 1'b1; c_r <= CW'(b1);
          end else if (trip_r && c_more) c_r <= CW'(c1);
          else if (b_more) begin
            b_r <= CW'(b1); trip_r <= 1'b0;
          end else if (a_more) begin
            a_r <= CW'(a1); b_r <= CW'(a2); trip_r <= 1'b0;
          end else begin
            k_r <= '0; dph_r <= DP_PAIR_GO;
          end
        bdj3_pkg::ST_DIV:
          case (dph_r)
            DP_PAIR_GO: dph_r <= DP_PAIR_WAIT;
            DP_PAIR_WAIT: if (ddone) begin
              dsum_r <= bdj3_pkg::DEPTH_W'(dq); dph_r <= DP_TRIP_GO;
            end
            DP_TRIP_GO: dph_r <= DP_TRIP_WAIT;
            default: if (ddone) begin
              dsum_r <= dsum_r + bdj3_pkg::DEPTH_W'(dq);
              ovalid_r <= 1'b1;
              last_r <= ({1'b0, k_r} + 1'b1) == n_eff;
            end
          endcase
        bdj3_pkg::ST_EMIT:
          if (out_fire) begin
            ovalid_r <= 1'b0; dph_r <= DP_PAIR_GO; k_r <= k_r + 1'b1;
          end
        default: ;
      endcase
    end
  end

  // Read tags are registered alongside the memory read so each returning word finds its use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_first_r <= 1'b0;
      rd_ext_r <= 1'b0;
      rd_test_r <= 1'b0;
    end else begin
      rd_first_r <= (st_r == bdj3_pkg::ST_SCAN) && sp_r == SP_A;
      rd_ext_r <= (st_r == bdj3_pkg::ST_SCAN) && (sp_r == SP_B || sp_r == SP_C);
      rd_test_r <= (st_r == bdj3_pkg::ST_SCAN) && sp_r == SP_CURVE;
    end
  end

  // Samples are kept in offset binary so that unsigned compares follow signed order.
  always_ff @(posedge clk) begin
    if (in_fire) mem[load_r[AW-1:0]] <= {~in_ch.data[SW-1], in_ch.data[SW-2:0]};
    rd_r <= mem[rd_addr];
    rd_cur_r <= i_r;
    if (rd_first_r) begin
      lo_r <= rd_r;
      hi_r <= rd_r;
    end else if (rd_ext_r) begin
      if (rd_r < lo_r) lo_r <= rd_r;
      if (rd_r > hi_r) hi_r <= rd_r;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_CURVES; g++) begin : g_cell
      bdj3_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .sel(rd_cur_r == CW'(g)),
        .active((CW+1)'(g) < n_eff),
        .samp(rd_r), .lo(lo_r), .hi(hi_r),
        .pair_in(pc[g+1]), .trip_in(tc[g+1]),
        .pair_out(pc[g]), .trip_out(tc[g])
      );
    end
  endgenerate

  assign out_ch.data.curve_number = bdj3_pkg::CURVE_NUM_W'(k_r);
  assign out_ch.data.pair_count = pc[0];
  assign out_ch.data.triple_count = tc[0];
  assign out_ch.data.depth_value = dsum_r;
  assign out_ch.data.last_result = last_r;
endmodule

>>> hdl/bdj3_check.sv
// Port-level checker for the band depth block, bound to the top level.
// Depends on band_depth_j3.
module bdj3_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind band_depth_j3 bdj3_check u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

>>> tb/band_depth_j3_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for band_depth_j3: loads curve frames, predicts band counts
// and depth per curve, and checks each result word. Depends on bdj3_pkg, bdj3_if, DUT.
module band_depth_j3_test;

  logic clk;
  logic rst_n;

  bdj3_if #(.payload_t(bdj3_pkg::sample_t)) in_ch ();
  bdj3_if #(.payload_t(bdj3_pkg::result_t)) out_ch ();
  bdj3_if #(.payload_t(bdj3_pkg::cfg_t))    cfg_ch ();

  band_depth_j3 dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predictor state.
  logic [bdj3_pkg::NCFG_W-1:0] curves_reg;
  logic [bdj3_pkg::PCFG_W-1:0] points_reg;
  logic signed [31:0]   frame_store [0:bdj3_pkg::MAX_CURVES_DEF*bdj3_pkg::MAX_POINTS_DEF-1];
  int unsigned          fill_index;
  bdj3_pkg::result_t    results_due [$];

  int  fail_count;
  int  words_sent;
  bit  idle_enable;
  int  out_hold;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int unsigned active_curves();
    if (curves_reg < 3) return 3;
    if (curves_reg > bdj3_pkg::MAX_CURVES_DEF) return bdj3_pkg::MAX_CURVES_DEF;
    return curves_reg;
  endfunction

  function automatic int unsigned active_points();
    if (points_reg < 1) return 1;
    if (points_reg > bdj3_pkg::MAX_POINTS_DEF) return bdj3_pkg::MAX_POINTS_DEF;
    return points_reg;
  endfunction

  // Counts, for every curve, the pair and triple bands that hold it at all points.
  task automatic tally_bands(input int unsigned n, input int unsigned p);
    int unsigned pairs [bdj3_pkg::MAX_CURVES_DEF];
    int unsigned triples [bdj3_pkg::MAX_CURVES_DEF];
    logic signed [31:0] lo2 [bdj3_pkg::MAX_POINTS_DEF];
    logic signed [31:0] hi2 [bdj3_pkg::MAX_POINTS_DEF];
    logic signed [31:0] lo3 [bdj3_pkg::MAX_POINTS_DEF];
    logic signed [31:0] hi3 [bdj3_pkg::MAX_POINTS_DEF];
    logic signed [31:0] v;
    longint unsigned c2, c3, depth;
    bdj3_pkg::result_t r;
    bit held;
    for (int i = 0; i < n; i++) begin
      pairs[i] = 0;
      triples[i] = 0;
    end
    for (int a = 0; a < n - 1; a++) begin
      for (int b = a + 1; b < n; b++) begin
        for (int j = 0; j < p; j++) begin
          lo2[j] = frame_store[j*n+a] < frame_store[j*n+b] ? frame_store[j*n+a]
                                                           : frame_store[j*n+b];
          hi2[j] = frame_store[j*n+a] > frame_store[j*n+b] ? frame_store[j*n+a]
                                                           : frame_store[j*n+b];
        end
        for (int i = 0; i < n; i++) begin
          held = 1;
          for (int j = 0; j < p; j++) begin
            v = frame_store[j*n+i];
            if (v < lo2[j] || v > hi2[j]) held = 0;
          end
          if (held) pairs[i]++;
        end
        for (int c = b + 1; c < n; c++) begin
          for (int j = 0; j < p; j++) begin
            v = frame_store[j*n+c];
            lo3[j] = v < lo2[j] ? v : lo2[j];
            hi3[j] = v > hi2[j] ? v : hi2[j];
          end
          for (int i = 0; i < n; i++) begin
            held = 1;
            for (int j = 0; j < p; j++) begin
              v = frame_store[j*n+i];
              if (v < lo3[j] || v > hi3[j]) held = 0;
            end
            if (held) triples[i]++;
          end
        end
      end
    end
    c2 = n * (n - 1) / 2;
    c3 = longint'(n) * (n - 1) * (n - 2) / 6;
    for (int i = 0; i < n; i++) begin
      depth = ((longint'(pairs[i]) << bdj3_pkg::FRAC_BITS) / c2)
            + ((longint'(triples[i]) << bdj3_pkg::FRAC_BITS) / c3);
      r.curve_number = i[bdj3_pkg::CURVE_NUM_W-1:0];
      r.pair_count   = pairs[i][bdj3_pkg::PAIR_CNT_W-1:0];
      r.triple_count = triples[i][bdj3_pkg::TRIPLE_CNT_W-1:0];
      r.depth_value  = depth[bdj3_pkg::DEPTH_W-1:0];
      r.last_result  = (i == n - 1);
      results_due.push_back(r);
    end
  endtask

  task automatic take_sample(input bdj3_pkg::sample_t w);
    int unsigned total;
    total = active_curves() * active_points();
    if (fill_index >= total) fill_index = 0;
    frame_store[fill_index] = w;
    fill_index++;
    if (fill_index == total) begin
      fill_index = 0;
      tally_bands(active_curves(), active_points());
    end
  endtask

  // Sends one sample word, with an optional idle burst before it.
  task automatic send_word(input bdj3_pkg::sample_t w);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    take_sample(w);
    words_sent++;
  endtask

  task automatic write_reg(input logic [bdj3_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    in_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.idx <= idx;
    cfg_ch.data.value <= value[bdj3_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == bdj3_pkg::REG_NUM_CURVES) curves_reg = value[bdj3_pkg::NCFG_W-1:0];
    else points_reg = value[bdj3_pkg::PCFG_W-1:0];
    fill_index = 0;
  endtask

  // Waits until every expected word has come back, then lets the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic bdj3_pkg::sample_t pick_sample(input int mode);
    case (mode)
      0: return bdj3_pkg::sample_t'($signed($urandom_range(0, 4)) - 2);
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_frame(input int mode);
    int unsigned total;
    total = active_curves() * active_points();
    for (int k = 0; k < total; k++) send_word(pick_sample(mode));
    drain();
  endtask

  task automatic setup(input int unsigned n, input int unsigned p);
    write_reg(bdj3_pkg::REG_NUM_CURVES, n);
    write_reg(bdj3_pkg::REG_NUM_POINTS, p);
  endtask

  task automatic test_register_saturation();
    // Out-of-range values clamp: 127 curves to 64, 511 points to 256, zero to the floor.
    setup(127, 511);
    repeat (5) send_word($urandom);
    setup(0, 0);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'h0000_0000);
    drain();
    setup(2, 1);
    send_frame(1);
  endtask

  task automatic test_ties_and_extremes();
    // Equal samples sit on both bounds at once, so every band holds every curve.
    setup(3, 2);
    repeat (6) send_word(32'h0000_0005);
    drain();
    setup(4, 2);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h0000_0001);
    send_word(32'h8000_0001);
    drain();
  endtask

  task automatic test_load_restart();
    setup(3, 2);
    repeat (4) send_word($urandom);
    in_ch.valid <= 1'b0;
    write_reg(bdj3_pkg::REG_NUM_POINTS, 2);
    send_frame(2);
  endtask

  task automatic test_random_frames();
    while (words_sent < 200) begin
      setup($urandom_range(3, 7), $urandom_range(1, 6));
      send_frame($urandom_range(0, 3));
    end
  endtask

  task automatic test_many_curves();
    setup(33, 1);
    send_frame(0);
  endtask

  task automatic test_no_idling();
    idle_enable = 0;
    repeat (3) begin
      setup($urandom_range(3, 5), $urandom_range(1, 3));
      send_frame($urandom_range(0, 2));
    end
  endtask

  // Result side: random stall bursts on out_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_hold = 0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ch.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(0, 14);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    bdj3_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result word %p", out_ch.data);
      end else begin
        want = results_due.pop_front();
        if (out_ch.data !== want) begin
          fail_count++;
          if (fail_count <= 10) $display("result mismatch: expected %p, got %p",
                                         want, out_ch.data);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("band_depth_j3 test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    curves_reg = 64;
    points_reg = 256;
    fill_index = 0;
    fail_count = 0;
    words_sent = 0;
    idle_enable = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_saturation();
    test_ties_and_extremes();
    test_load_restart();
    test_random_frames();
    test_many_curves();
    test_no_idling();
    drain();
    if (fail_count == 0) begin
      $display("band_depth_j3 test passed");
    end else begin
      $display("band_depth_j3 test failed");
    end
    $finish;
  end
endmodule

>>> band_depth_j3.f
hdl/bdj3_pkg.sv
hdl/bdj3_if.sv
hdl/bdj3_cell.sv
hdl/bdj3_div.sv
hdl/band_depth_j3.sv
hdl/bdj3_check.sv
tb/band_depth_j3_test.sv
